// ===== src/fsrd_pkg.sv =====
package fsrd_pkg;

  // Fixed limits of the design
  localparam int unsigned MAX_STEPS    = 32'd65536;
  localparam int unsigned MAX_ELEMENTS = 32'd65536;
  localparam int unsigned INDEX_CEIL   = 32'd65536;

  localparam int CFG_W   = 17;
  localparam int TDATA_W = 88;
  localparam int TUSER_W = 2;

  // Configuration register indexes
  localparam logic [1:0] CFG_SERIES_LENGTH = 2'd0;
  localparam logic [1:0] CFG_ELEMENT_LIMIT = 2'd1;
  localparam logic [1:0] CFG_BIG_ENDIAN    = 2'd2;

  localparam logic [CFG_W-1:0] CFG_LIMIT_RESET = 17'h10000;

  // Record kinds
  localparam logic [1:0] KIND_START   = 2'd0;
  localparam logic [1:0] KIND_RUN     = 2'd1;
  localparam logic [1:0] KIND_LITERAL = 2'd2;
  localparam logic [1:0] KIND_EMPTY   = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_TYPE     = 2'd1;
  localparam logic [1:0] ERR_PAST_END = 2'd2;
  localparam logic [1:0] ERR_INDEX    = 2'd3;

  // Group header types
  localparam logic [1:0] GRP_ZERO    = 2'd0;
  localparam logic [1:0] GRP_LITERAL = 2'd1;
  localparam logic [1:0] GRP_REPEAT  = 2'd2;
  localparam logic [1:0] GRP_FLAGGED = 2'd3;

  localparam logic [16:0] POS_MAX = 17'h1FFFF;

  typedef enum logic [5:0] {
    PH_COUNT   = 6'b000001,
    PH_INDEX   = 6'b000010,
    PH_GROUPS  = 6'b000100,
    PH_HEADER  = 6'b001000,
    PH_LITERAL = 6'b010000,
    PH_VALUE   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [CFG_W-1:0] series_length;
    logic [CFG_W-1:0] element_limit;
    logic             big_endian;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] series_index;
    logic [15:0] start_step;
    logic [31:0] value_bits;
    logic [13:0] run_length;
    logic        last_of_series;
    logic        last_of_section;
    logic [1:0]  error;
  } rec_t;

endpackage

// ===== src/fsrd_parser.sv =====
module fsrd_parser #(
  parameter int unsigned MAX_STEPS    = fsrd_pkg::MAX_STEPS,
  parameter int unsigned MAX_ELEMENTS = fsrd_pkg::MAX_ELEMENTS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_take,
  input  logic [7:0]          in_byte,
  input  fsrd_pkg::cfg_t      cfg,
  output logic                rec_valid,
  output fsrd_pkg::rec_t      rec
);

  fsrd_pkg::phase_t phase, phase_next;
  logic [1:0]  byte_count, byte_count_next;
  logic [31:0] assembly, assembly_next;
  logic [31:0] series_left, series_left_next;
  logic [15:0] groups_left, groups_left_next;
  logic [13:0] literals_left, literals_left_next;
  logic [13:0] group_count, group_count_next;
  logic [16:0] position, position_next;
  logic [15:0] current_index, current_index_next;
  logic        index_bad, index_bad_next;

  logic [1:0]  bc_inc;
  logic [31:0] asm_le;
  logic [31:0] v;
  logic        done;
  logic [13:0] adv_len;
  logic [17:0] adv_sum;
  logic        adv_err;
  logic [16:0] adv_pos;
  logic [15:0] gl_dec;
  logic [31:0] sl_dec;
  logic [13:0] ll_dec;
  logic        eg_last;
  logic        eg_lsec;
  logic [1:0]  hdr_type;
  logic [13:0] hdr_count;

  assign bc_inc = byte_count + 2'd1;
  assign asm_le = assembly | (32'(in_byte) << {byte_count, 3'b000});
  assign v      = cfg.big_endian ? {assembly[23:0], in_byte} : asm_le;
  // Two-byte fields in the group count and header phases, four elsewhere
  assign done   = (phase == fsrd_pkg::PH_GROUPS || phase == fsrd_pkg::PH_HEADER) ?
                  (bc_inc == 2'd2) : (bc_inc == 2'd0);

  assign hdr_type  = v[15:14];
  assign hdr_count = v[13:0];

  always_comb begin
    case (phase)
      fsrd_pkg::PH_LITERAL: adv_len = 14'd1;
      fsrd_pkg::PH_VALUE:   adv_len = group_count;
      default:              adv_len = hdr_count;
    endcase
  end

  // Step advance with past-end check and saturation
  assign adv_sum = {1'b0, position} + 18'(adv_len);
  assign adv_err = (32'(adv_sum) > 32'(cfg.series_length)) ||
                   (32'(adv_sum) > MAX_STEPS);
  assign adv_pos = adv_sum[17] ? fsrd_pkg::POS_MAX : adv_sum[16:0];

  assign gl_dec  = groups_left - 16'd1;
  assign sl_dec  = series_left - 32'd1;
  assign ll_dec  = literals_left - 14'd1;
  assign eg_last = (gl_dec == 16'd0);
  assign eg_lsec = (sl_dec == 32'd0);

  always_comb begin
    phase_next         = phase;
    byte_count_next    = bc_inc;
    assembly_next      = v;
    series_left_next   = series_left;
    groups_left_next   = groups_left;
    literals_left_next = literals_left;
    group_count_next   = group_count;
    position_next      = position;
    current_index_next = current_index;
    index_bad_next     = index_bad;
    rec_valid          = 1'b0;
    rec                = '0;
    rec.series_index   = current_index;

    if (done) begin
      byte_count_next = 2'd0;
      assembly_next   = '0;
      case (phase)
        fsrd_pkg::PH_COUNT: begin
          if (v == 32'd0 || v[31]) begin
            current_index_next  = '0;
            rec_valid           = 1'b1;
            rec.kind            = fsrd_pkg::KIND_EMPTY;
            rec.series_index    = '0;
            rec.last_of_section = 1'b1;
          end else begin
            series_left_next = v;
            phase_next       = fsrd_pkg::PH_INDEX;
          end
        end
        fsrd_pkg::PH_INDEX: begin
          index_bad_next = (v == 32'd0) || (v > 32'(cfg.element_limit)) ||
                           (v > MAX_ELEMENTS) || (v > fsrd_pkg::INDEX_CEIL);
          current_index_next = 16'(v - 32'd1);
          phase_next         = fsrd_pkg::PH_GROUPS;
        end
        fsrd_pkg::PH_GROUPS: begin
          groups_left_next = v[15:0];
          position_next    = '0;
          rec_valid        = 1'b1;
          rec.kind         = fsrd_pkg::KIND_START;
          rec.error        = index_bad ? fsrd_pkg::ERR_INDEX : fsrd_pkg::ERR_NONE;
          if (v[15:0] == 16'd0) begin
            // series without groups ends on its start record
            series_left_next    = sl_dec;
            rec.last_of_series  = 1'b1;
            rec.last_of_section = eg_lsec;
            phase_next = eg_lsec ? fsrd_pkg::PH_COUNT : fsrd_pkg::PH_INDEX;
          end else begin
            phase_next = fsrd_pkg::PH_HEADER;
          end
        end
        fsrd_pkg::PH_HEADER: begin
          group_count_next = hdr_count;
          if (hdr_type == fsrd_pkg::GRP_REPEAT) begin
            phase_next = fsrd_pkg::PH_VALUE;
          end else if (hdr_type == fsrd_pkg::GRP_LITERAL && hdr_count != 14'd0) begin
            literals_left_next = hdr_count;
            phase_next         = fsrd_pkg::PH_LITERAL;
          end else begin
            // zero run, empty literal group or flagged type
            rec_valid      = 1'b1;
            rec.kind       = fsrd_pkg::KIND_RUN;
            rec.start_step = position[15:0];
            rec.run_length = hdr_count;
            position_next  = adv_pos;
            if (hdr_type == fsrd_pkg::GRP_FLAGGED) begin
              rec.error = fsrd_pkg::ERR_TYPE;
            end else begin
              rec.error = adv_err ? fsrd_pkg::ERR_PAST_END : fsrd_pkg::ERR_NONE;
            end
            groups_left_next   = gl_dec;
            rec.last_of_series = eg_last;
            if (eg_last) begin
              series_left_next    = sl_dec;
              rec.last_of_section = eg_lsec;
              phase_next = eg_lsec ? fsrd_pkg::PH_COUNT : fsrd_pkg::PH_INDEX;
            end else begin
              phase_next = fsrd_pkg::PH_HEADER;
            end
          end
        end
        fsrd_pkg::PH_VALUE: begin
          rec_valid          = 1'b1;
          rec.kind           = fsrd_pkg::KIND_RUN;
          rec.start_step     = position[15:0];
          rec.value_bits     = v;
          rec.run_length     = group_count;
          rec.error          = adv_err ? fsrd_pkg::ERR_PAST_END : fsrd_pkg::ERR_NONE;
          position_next      = adv_pos;
          groups_left_next   = gl_dec;
          rec.last_of_series = eg_last;
          if (eg_last) begin
            series_left_next    = sl_dec;
            rec.last_of_section = eg_lsec;
            phase_next = eg_lsec ? fsrd_pkg::PH_COUNT : fsrd_pkg::PH_INDEX;
          end else begin
            phase_next = fsrd_pkg::PH_HEADER;
          end
        end
        fsrd_pkg::PH_LITERAL: begin
          rec_valid          = 1'b1;
          rec.kind           = fsrd_pkg::KIND_LITERAL;
          rec.start_step     = position[15:0];
          rec.value_bits     = v;
          rec.run_length     = 14'd1;
          rec.error          = adv_err ? fsrd_pkg::ERR_PAST_END : fsrd_pkg::ERR_NONE;
          position_next      = adv_pos;
          literals_left_next = ll_dec;
          if (ll_dec == 14'd0) begin
            groups_left_next   = gl_dec;
            rec.last_of_series = eg_last;
            if (eg_last) begin
              series_left_next    = sl_dec;
              rec.last_of_section = eg_lsec;
              phase_next = eg_lsec ? fsrd_pkg::PH_COUNT : fsrd_pkg::PH_INDEX;
            end else begin
              phase_next = fsrd_pkg::PH_HEADER;
            end
          end
        end
        default: begin
          phase_next = fsrd_pkg::PH_COUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= fsrd_pkg::PH_COUNT;
      byte_count    <= '0;
      assembly      <= '0;
      series_left   <= '0;
      groups_left   <= '0;
      literals_left <= '0;
      group_count   <= '0;
      position      <= '0;
      current_index <= '0;
      index_bad     <= 1'b0;
    end else if (in_take) begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      assembly      <= assembly_next;
      series_left   <= series_left_next;
      groups_left   <= groups_left_next;
      literals_left <= literals_left_next;
      group_count   <= group_count_next;
      position      <= position_next;
      current_index <= current_index_next;
      index_bad     <= index_bad_next;
    end
  end

endmodule

// ===== src/float_series_rle_decoder.sv =====
// Channel   | Dir | Bits            | Contents
// s_axis    | in  | tdata[7:0]      | stream_byte
// m_axis    | out | tdata/tuser/tlast | one record per series start, run, literal, empty section
// cfg       | in  | we/index/data   | series_length, element_limit, big_endian
//
// One byte is taken per cycle while s_tvalid and s_tready are high; the parser
// state advances in a single registered step. A record shows on m_axis the
// cycle after the byte that completes its field. s_tready drops only while a
// record sits in the output register and m_tready is low. Reset (rst, synchronous)
// returns the parser to expecting a series count and the registers to their defaults.
module float_series_rle_decoder #(
  parameter int unsigned MAX_STEPS    = fsrd_pkg::MAX_STEPS,
  parameter int unsigned MAX_ELEMENTS = fsrd_pkg::MAX_ELEMENTS
) (
  input  logic                          clk,
  input  logic                          rst,
  // stream input
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] stream_byte
  // record output
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [15:0] series_index, [31:16] start_step, [63:32] value_bits,
  // [77:64] run_length, [78] last_of_series, [80:79] error, [87:81] zero
  output logic [fsrd_pkg::TDATA_W-1:0]  m_tdata,
  output logic [fsrd_pkg::TUSER_W-1:0]  m_tuser,   // [1:0] kind
  output logic                          m_tlast,   // last_of_section
  // configuration writes
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [fsrd_pkg::CFG_W-1:0]    cfg_data
);

  fsrd_pkg::cfg_t cfg;
  fsrd_pkg::rec_t rec;
  fsrd_pkg::rec_t out_rec;
  logic           rec_valid;
  logic           in_take;

  // Output register decouples the two sides; an offered byte is taken whenever the
  // register is empty or being drained this cycle.
  assign s_tready = !m_tvalid || m_tready;
  assign in_take  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.series_length <= fsrd_pkg::CFG_LIMIT_RESET;
      cfg.element_limit <= fsrd_pkg::CFG_LIMIT_RESET;
      cfg.big_endian    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        fsrd_pkg::CFG_SERIES_LENGTH: cfg.series_length <= cfg_data;
        fsrd_pkg::CFG_ELEMENT_LIMIT: cfg.element_limit <= cfg_data;
        fsrd_pkg::CFG_BIG_ENDIAN:    cfg.big_endian    <= cfg_data[0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  fsrd_parser #(
    .MAX_STEPS    (MAX_STEPS),
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_take   (in_take),
    .in_byte   (s_tdata),
    .cfg       (cfg),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (in_take && rec_valid) begin
        m_tvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && rec_valid) begin
      out_rec <= rec;
    end
  end

  assign m_tdata = {7'b0, out_rec.error, out_rec.last_of_series, out_rec.run_length,
                    out_rec.value_bits, out_rec.start_step, out_rec.series_index};
  assign m_tuser = out_rec.kind;
  assign m_tlast = out_rec.last_of_section;

endmodule

// ===== src/fsrd_checker.sv =====
module fsrd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [fsrd_pkg::TDATA_W-1:0]  m_tdata,
  input logic [fsrd_pkg::TUSER_W-1:0]  m_tuser,
  input logic                          m_tlast
);

  // held record must not change while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("record changed while stalled");

  // input never stalls while the output register is empty
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // empty-section record ends the section and carries nothing else
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == fsrd_pkg::KIND_EMPTY |-> m_tlast && m_tdata == '0)
    else $error("malformed empty-section record");

  // index error only on series start records
  a_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[80:79] == fsrd_pkg::ERR_INDEX |->
      m_tuser == fsrd_pkg::KIND_START)
    else $error("index error on non-start record");

  // literal fills exactly one step
  a_literal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == fsrd_pkg::KIND_LITERAL |-> m_tdata[77:64] == 14'd1)
    else $error("literal with run length other than one");

endmodule

bind float_series_rle_decoder fsrd_checker u_fsrd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
